>>> rtl/gprp_pkg.sv
// Shared constants, types and helpers for the grid point rotate and project pipeline.
package gprp_pkg;

    localparam logic [2:0] CFG_PLAYER_X = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [2:0] CFG_MOVE_X   = 3'd2;
    localparam logic [2:0] CFG_MOVE_Y   = 3'd3;

    localparam logic signed [23:0] PLAYER_X_RST = 24'sd245760;
    localparam logic signed [23:0] PLAYER_Y_RST = 24'sd276480;

    localparam int SCALED_W    = 28;
    localparam int POS_W       = 30;
    localparam int TRIG_W      = 18;
    localparam int TRIG_STAGES = 7;
    localparam int ROT_W       = 32;
    localparam int PROD_W      = 48;
    localparam int NUM_W       = 41;
    localparam int DEN_W       = 32;
    localparam int PIPE_LAT    = 56;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [14:0] QUARTER_F    = 15'd16384;
    localparam logic [16:0] ONE_Q16      = 17'd65536;

    localparam logic [16:0] SC1 = 17'd102944;
    localparam logic [16:0] SC3 = 17'd42334;
    localparam logic [16:0] SC5 = 17'd5223;
    localparam logic [16:0] SC7 = 17'd307;
    localparam logic [16:0] SC9 = 17'd11;
    localparam logic [16:0] SC_COEF [4] = '{SC7, SC5, SC3, SC1};

    localparam logic [NUM_W-1:0] PROJ_K   = 41'd2000;
    localparam logic [NUM_W-1:0] LEN_NUM  = 41'd9830400000;
    localparam logic signed [PROD_W-1:0] LEN_BIAS = 48'sd1280;

    localparam logic signed [23:0] Q24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q24_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [15:0]      elev;
    } t_rot_side;

    typedef struct packed {
        logic                    nx_pos;
        logic                    nx_neg;
        logic                    ny_neg;
        logic                    ny_zero;
        logic signed [ROT_W-1:0] ny;
        logic signed [15:0]      elev;
    } t_div_side;

    function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
        logic signed [23:0] res;
        if (v > 48'(Q24_MAX)) begin
            res = Q24_MAX;
        end else if (v < 48'(Q24_MIN)) begin
            res = Q24_MIN;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/gprp_trig.sv
// Pipelined sine and cosine of a turn-fraction angle by a folded odd polynomial.
module gprp_trig import gprp_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [15:0]              i_angle,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic [SIDE_W-1:0]        o_side
);

    logic [TRIG_STAGES-1:0]   r_v;
    logic [SIDE_W-1:0]        r_side [TRIG_STAGES];
    logic signed [TRIG_W-1:0] w_res [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[TRIG_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int k = 1; k < TRIG_STAGES; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [15:0]              w_a;
        logic [14:0]              w_f;
        logic [33:0]              w_r;
        logic [16:0]              w_rc;
        logic [16:0]              r_u  [6];
        logic [1:0]               r_q  [6];
        logic [16:0]              r_u2 [4];
        logic [16:0]              r_s  [4];
        logic signed [TRIG_W-1:0] r_res;

        assign w_a  = (l == 0) ? i_angle : 16'(i_angle + QUARTER_TURN);
        assign w_f  = w_a[14] ? 15'(QUARTER_F - {1'b0, w_a[13:0]}) : {1'b0, w_a[13:0]};
        assign w_r  = (34'(r_s[3]) * 34'(r_u[5])) >> 16;
        assign w_rc = (w_r > 34'(ONE_Q16)) ? ONE_Q16 : w_r[16:0];

        always_ff @(posedge i_clk) begin
            r_u[0]  <= {w_f, 2'b00};
            r_q[0]  <= w_a[15:14];
            for (int k = 1; k < 6; k++) begin
                r_u[k] <= r_u[k-1];
                r_q[k] <= r_q[k-1];
            end
            r_u2[0] <= 17'((34'(r_u[0]) * 34'(r_u[0])) >> 16);
            for (int k = 1; k < 4; k++) begin
                r_u2[k] <= r_u2[k-1];
            end
            r_s[0] <= SC_COEF[0] - 17'((34'(SC9) * 34'(r_u2[0])) >> 16);
            for (int k = 1; k < 4; k++) begin
                r_s[k] <= SC_COEF[k] - 17'((34'(r_s[k-1]) * 34'(r_u2[k])) >> 16);
            end
            r_res <= r_q[5][1] ? -$signed({1'b0, w_rc}) : $signed({1'b0, w_rc});
        end

        assign w_res[l] = r_res;
    end

    assign o_valid = r_v[TRIG_STAGES-1];
    assign o_side  = r_side[TRIG_STAGES-1];
    assign o_sin   = w_res[0];
    assign o_cos   = w_res[1];

endmodule

>>> rtl/gprp_div.sv
// Pipelined restoring divider: two dividends over one divisor, one quotient bit per stage.
module gprp_div import gprp_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num_a,
    input  logic [NUM_W-1:0]  i_num_b,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo_a,
    output logic [NUM_W-1:0]  o_quo_b,
    output logic [SIDE_W-1:0] o_side
);

    logic              w_v     [NUM_W+1];
    logic [NUM_W-1:0]  w_aq_a  [NUM_W+1];
    logic [NUM_W-1:0]  w_aq_b  [NUM_W+1];
    logic [DEN_W-1:0]  w_rem_a [NUM_W+1];
    logic [DEN_W-1:0]  w_rem_b [NUM_W+1];
    logic [DEN_W-1:0]  w_den   [NUM_W+1];
    logic [SIDE_W-1:0] w_side  [NUM_W+1];

    assign w_v[0]     = i_valid;
    assign w_aq_a[0]  = i_num_a;
    assign w_aq_b[0]  = i_num_b;
    assign w_rem_a[0] = '0;
    assign w_rem_b[0] = '0;
    assign w_den[0]   = i_den;
    assign w_side[0]  = i_side;

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0]    w_ta;
        logic [DEN_W:0]    w_tb;
        logic              w_ge_a;
        logic              w_ge_b;
        logic              r_v;
        logic [NUM_W-1:0]  r_aq_a;
        logic [NUM_W-1:0]  r_aq_b;
        logic [DEN_W-1:0]  r_rem_a;
        logic [DEN_W-1:0]  r_rem_b;
        logic [DEN_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;

        assign w_ta   = {w_rem_a[s], w_aq_a[s][NUM_W-1]};
        assign w_tb   = {w_rem_b[s], w_aq_b[s][NUM_W-1]};
        assign w_ge_a = w_ta >= {1'b0, w_den[s]};
        assign w_ge_b = w_tb >= {1'b0, w_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem_a <= w_ge_a ? DEN_W'(w_ta - {1'b0, w_den[s]}) : w_ta[DEN_W-1:0];
            r_rem_b <= w_ge_b ? DEN_W'(w_tb - {1'b0, w_den[s]}) : w_tb[DEN_W-1:0];
            r_aq_a  <= {w_aq_a[s][NUM_W-2:0], w_ge_a};
            r_aq_b  <= {w_aq_b[s][NUM_W-2:0], w_ge_b};
            r_den   <= w_den[s];
            r_side  <= w_side[s];
        end

        assign w_v[s+1]     = r_v;
        assign w_aq_a[s+1]  = r_aq_a;
        assign w_aq_b[s+1]  = r_aq_b;
        assign w_rem_a[s+1] = r_rem_a;
        assign w_rem_b[s+1] = r_rem_b;
        assign w_den[s+1]   = r_den;
        assign w_side[s+1]  = r_side;
    end

    assign o_valid = w_v[NUM_W];
    assign o_quo_a = w_aq_a[NUM_W];
    assign o_quo_b = w_aq_b[NUM_W];
    assign o_side  = w_side[NUM_W];

endmodule

>>> rtl/grid_point_rotate_project.sv
// Top level: grid cell to rotated, perspective-projected screen point and pillar.
//
// Command channel: an item is taken at a rising edge with start high and busy low.
// busy stays low: a new item may be given in every cycle.
// Result channel: o_valid marks one cycle in which all result fields are valid;
// the result transfers at the edge that ends that cycle and cannot be held off.
// Pipeline: the 41-stage divider, seven sine/cosine stages and eight stages of
// scaling, rotation, sign fixing and saturation lie between the accepting edge
// and the result transfer edge. Throughput: one item per cycle.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (player x,
// player y, move x, move y); other indexes are dropped. Write only while idle.
// Reset clears all pipeline valid bits and restores the register defaults;
// items in flight are lost.
module grid_point_rotate_project import gprp_pkg::*; #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080,
    parameter int GRID_COLS     = 20,
    parameter int GRID_ROWS     = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_wdata,
    input  logic [5:0]         i_grid_col,
    input  logic [5:0]         i_grid_row,
    input  logic [15:0]        i_view_angle,
    input  logic signed [15:0] i_elevation,
    output logic               o_valid,
    output logic signed [23:0] o_screen_x,
    output logic signed [23:0] o_depth_y,
    output logic signed [23:0] o_pillar_length,
    output logic signed [23:0] o_top_y,
    output logic signed [23:0] o_bottom_y,
    output logic               o_visible
);

    localparam int LUT_N = 64;
    localparam longint H2_Q16 = longint'(SCREEN_HEIGHT / 2) * 65536;

    logic signed [23:0] r_player_x;
    logic signed [23:0] r_player_y;
    logic signed [23:0] r_move_x;
    logic signed [23:0] r_move_y;

    logic [SCALED_W-1:0] w_col_lut [LUT_N];
    logic [SCALED_W-1:0] w_row_lut [LUT_N];

    for (genvar gi = 0; gi < LUT_N; gi++) begin : g_lut
        localparam longint XV = (longint'(gi) * SCREEN_WIDTH * 256) / GRID_COLS;
        localparam longint YV = (longint'(gi) * SCREEN_HEIGHT * 256) / GRID_ROWS;
        assign w_col_lut[gi] = SCALED_W'(XV);
        assign w_row_lut[gi] = SCALED_W'(YV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= PLAYER_X_RST;
            r_player_y <= PLAYER_Y_RST;
            r_move_x   <= '0;
            r_move_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLAYER_X: r_player_x <= i_cfg_wdata;
                CFG_PLAYER_Y: r_player_y <= i_cfg_wdata;
                CFG_MOVE_X:   r_move_x   <= i_cfg_wdata;
                CFG_MOVE_Y:   r_move_y   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // scale cell
    logic                r1_v;
    logic [SCALED_W-1:0] r1_xs;
    logic [SCALED_W-1:0] r1_ys;
    logic [15:0]         r1_ang;
    logic signed [15:0]  r1_elev;

    // offset
    logic                r2_v;
    logic [15:0]         r2_ang;
    t_rot_side           r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_xs   <= w_col_lut[i_grid_col];
        r1_ys   <= w_row_lut[i_grid_row];
        r1_ang  <= i_view_angle;
        r1_elev <= i_elevation;
        r2_ang  <= r1_ang;
        r2_side.x <= $signed({2'b00, r1_xs}) - POS_W'(r_player_x) + POS_W'(r_move_x);
        r2_side.y <= $signed({2'b00, r1_ys}) - POS_W'(r_player_y) + POS_W'(r_move_y);
        r2_side.elev <= r1_elev;
    end

    logic                     w_tv;
    logic signed [TRIG_W-1:0] w_sin;
    logic signed [TRIG_W-1:0] w_cos;
    logic [$bits(t_rot_side)-1:0] w_tside;
    t_rot_side                w_ts;

    gprp_trig #(
        .SIDE_W ($bits(t_rot_side))
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_angle (r2_ang),
        .i_side  (r2_side),
        .o_valid (w_tv),
        .o_sin   (w_sin),
        .o_cos   (w_cos),
        .o_side  (w_tside)
    );

    assign w_ts = t_rot_side'(w_tside);

    // rotate
    logic                     r3_v;
    logic signed [PROD_W-1:0] r3_xc;
    logic signed [PROD_W-1:0] r3_ys;
    logic signed [PROD_W-1:0] r3_yc;
    logic signed [PROD_W-1:0] r3_xs;
    logic signed [15:0]       r3_elev;

    logic                     r4_v;
    logic signed [ROT_W-1:0]  r4_nx;
    logic signed [ROT_W-1:0]  r4_ny;
    logic signed [15:0]       r4_elev;

    logic [PROD_W-1:0] w_dxy;
    logic [PROD_W-1:0] w_dyx;

    assign w_dxy = (r3_xc - r3_ys) >>> 16;
    assign w_dyx = (r3_yc + r3_xs) >>> 16;

    // divider operands
    logic                r5_v;
    logic [NUM_W-1:0]    r5_num;
    logic [DEN_W-1:0]    r5_den;
    t_div_side           r5_side;
    logic [ROT_W-1:0]    w_nx_mag;

    assign w_nx_mag = r4_nx[ROT_W-1] ? ROT_W'(-r4_nx) : r4_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r3_v <= w_tv;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_xc   <= w_ts.x * w_cos;
        r3_ys   <= w_ts.y * w_sin;
        r3_yc   <= w_ts.y * w_cos;
        r3_xs   <= w_ts.x * w_sin;
        r3_elev <= w_ts.elev;
        r4_nx   <= ROT_W'(w_dxy);
        r4_ny   <= ROT_W'(w_dyx);
        r4_elev <= r3_elev;
        r5_num  <= NUM_W'(w_nx_mag) * PROJ_K;
        r5_den  <= r4_ny[ROT_W-1] ? DEN_W'(-r4_ny) : DEN_W'(r4_ny);
        r5_side.nx_pos  <= !r4_nx[ROT_W-1] && (r4_nx != '0);
        r5_side.nx_neg  <= r4_nx[ROT_W-1];
        r5_side.ny_neg  <= r4_ny[ROT_W-1];
        r5_side.ny_zero <= (r4_ny == '0);
        r5_side.ny      <= r4_ny;
        r5_side.elev    <= r4_elev;
    end

    logic                         w_dv;
    logic [NUM_W-1:0]             w_qa;
    logic [NUM_W-1:0]             w_qb;
    logic [$bits(t_div_side)-1:0] w_dside;
    t_div_side                    w_ds;

    gprp_div #(
        .SIDE_W ($bits(t_div_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_num_a (r5_num),
        .i_num_b (LEN_NUM),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (w_dv),
        .o_quo_a (w_qa),
        .o_quo_b (w_qb),
        .o_side  (w_dside)
    );

    assign w_ds = t_div_side'(w_dside);

    // sign fix
    logic                     r6_v;
    logic signed [PROD_W-1:0] r6_proj;
    logic signed [23:0]       r6_len;
    logic signed [ROT_W-1:0]  r6_ny;
    logic signed [15:0]       r6_elev;

    logic signed [PROD_W-1:0] w_proj;
    logic signed [PROD_W-1:0] w_qbs;
    logic signed [23:0]       w_len;

    always_comb begin
        w_qbs = w_ds.ny_neg ? -$signed(PROD_W'(w_qb)) : $signed(PROD_W'(w_qb));
        if (w_ds.ny_zero) begin
            if (w_ds.nx_pos) begin
                w_proj = PROD_W'(Q24_MIN);
            end else if (w_ds.nx_neg) begin
                w_proj = PROD_W'(Q24_MAX);
            end else begin
                w_proj = '0;
            end
            w_len = Q24_MAX;
        end else begin
            if (w_ds.nx_pos ^ w_ds.ny_neg) begin
                w_proj = -$signed(PROD_W'(w_qa));
            end else begin
                w_proj = $signed(PROD_W'(w_qa));
            end
            w_len = sat24(LEN_BIAS + w_qbs);
        end
    end

    // offset, depth and elevation product
    logic                     r7_v;
    logic signed [23:0]       r7_sx;
    logic signed [23:0]       r7_dy;
    logic signed [23:0]       r7_len;
    logic signed [40:0]       r7_prod;
    logic                     r7_vis;
    logic signed [16:0]       w_em;

    assign w_em = 17'(r6_elev) - 17'sd256;

    logic signed [PROD_W-1:0] w_base;
    logic signed [PROD_W-1:0] w_t16;
    logic signed [PROD_W-1:0] w_b16;

    assign w_base = PROD_W'(H2_Q16) - PROD_W'(r7_prod);
    assign w_t16  = w_base - (PROD_W'(r7_len) <<< 7);
    assign w_b16  = w_base + (PROD_W'(r7_len) <<< 7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r6_v    <= w_dv;
            r7_v    <= r6_v;
            o_valid <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_proj <= w_proj;
        r6_len  <= w_len;
        r6_ny   <= w_ds.ny;
        r6_elev <= w_ds.elev;
        r7_sx   <= sat24(PROD_W'(r_player_x) + r6_proj);
        r7_dy   <= sat24(PROD_W'(r6_ny) + PROD_W'(r_player_y));
        r7_len  <= r6_len;
        r7_prod <= r6_len * w_em;
        r7_vis  <= r6_ny[ROT_W-1];
        o_screen_x      <= r7_sx;
        o_depth_y       <= r7_dy;
        o_pillar_length <= r7_len;
        o_top_y         <= sat24(w_t16 >>> 8);
        o_bottom_y      <= sat24(w_b16 >>> 8);
        o_visible       <= r7_vis;
    end

endmodule

>>> rtl/gprp_chk.sv
// Port-level checker for the grid point rotate and project block, with its bind.
module gprp_chk import gprp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [23:0] o_pillar_length,
    input logic signed [23:0] o_top_y,
    input logic signed [23:0] o_bottom_y,
    input logic               o_visible
);

    a_result_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a command");

    a_cmd_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("command lost");

    a_pillar_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pillar_length >= 0)) |-> (o_bottom_y >= o_top_y))
        else $error("pillar ends out of order");

    a_behind_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_pillar_length >= 24'sd1280))
        else $error("pillar too short behind player");

endmodule

bind grid_point_rotate_project gprp_chk u_gprp_chk (.*);
